// ===== src/ffba_pkg.sv =====
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants of the first-fit block allocator: item
// structs, block table entry, status codes and chain control.
// ----------------------------------------------------------------------------
package ffba_pkg;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // smallest leftover payload that still justifies a split
    localparam logic [17:0] SPLIT_SLACK = 18'd8;

    localparam int BREAK_W = 17;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_OOM     = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_BADADDR = 2'd3
    } t_status;

    typedef struct packed {
        logic        opcode;
        logic [15:0] request_size;
        logic [15:0] free_address;
    } t_in_item;

    typedef struct packed {
        logic [15:0] payload_address;
        t_status     status;
    } t_out_item;

    typedef struct packed {
        logic [15:0] start;
        logic [15:0] size;
        logic        free;
        logic        valid;
    } t_entry;

    typedef struct packed {
        logic shift;
        logic compact;
        logic phase;
    } t_chain_ctl;

endpackage

// ===== src/first_fit_block_allocator_core.sv =====
// ----------------------------------------------------------------------------
// first_fit_block_allocator_core
// First-fit heap allocator with block split and free-block merging, built
// as a ring of table cells around one processing head.
// ----------------------------------------------------------------------------
// Input item: opcode (allocate or free), request_size, free_address, taken on
// i_in_valid & o_in_ready. Result item: payload_address and status, offered on
// o_out_valid until i_out_ready. One item is in work at a time.
// An allocate rotates the whole table once past the head. A free takes the
// same scan, during which the block is marked and merged with its free
// neighbors, followed by a check and an odd-even compaction of the table
// that runs until the valid entries form a run from index zero. A free of
// address zero skips the scan and goes straight to the result. The input is
// ready again in the cycle in which the result is loaded.
// The rate is set by the ring: one table entry passes the head per cycle.
// Reset clears the table valid marks, the heap break and the result register;
// the block is ready in the first cycle after reset. A stalled receiver holds
// the result in the output register; the next item may be accepted meanwhile
// and its result waits until the register is free.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_core #(
    parameter int HEAP_BYTES   = 65536,
    parameter int MAX_BLOCKS   = 32,
    parameter int HEADER_BYTES = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ffba_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ffba_pkg::t_out_item o_out_item
);

    ffba_pkg::t_entry     entry [MAX_BLOCKS];
    ffba_pkg::t_entry     y;
    ffba_pkg::t_chain_ctl ctl;
    logic [MAX_BLOCKS-1:0] vmask;
    logic [MAX_BLOCKS-1:0] vmask_inc;
    logic                 packed_ok;

    assign vmask_inc = vmask + {{(MAX_BLOCKS-1){1'b0}}, 1'b1};
    // valid marks form a run from index zero
    assign packed_ok = ((vmask_inc & vmask) == '0);

    for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
        ffba_pkg::t_entry right;
        logic             left_valid;
        logic             lower;

        if (k == MAX_BLOCKS - 1) begin : g_tail
            assign right = y;
        end else begin : g_mid
            assign right = entry[k+1];
        end

        if (k == 0) begin : g_first
            assign left_valid = 1'b1;
        end else begin : g_rest
            assign left_valid = entry[k-1].valid;
        end

        if (k % 2 == 0) begin : g_even
            assign lower = ~ctl.phase;
        end else begin : g_odd
            assign lower = ctl.phase;
        end

        assign vmask[k] = entry[k].valid;

        ffba_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (ctl),
            .i_lower      (lower),
            .i_right      (right),
            .i_left_valid (left_valid),
            .o_entry      (entry[k])
        );
    end

    ffba_head #(
        .HEAP_BYTES   (HEAP_BYTES),
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_head (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_item   (o_out_item),
        .i_head       (entry[0]),
        .i_tail_valid (entry[MAX_BLOCKS-1].valid),
        .i_packed     (packed_ok),
        .o_ctl        (ctl),
        .o_y          (y)
    );

endmodule

// ===== src/ffba_cell.sv =====
// ----------------------------------------------------------------------------
// ffba_cell
// One block table entry. Shifts toward the head of the ring, or takes part
// in an odd-even compaction step that moves valid entries to low indices.
// ----------------------------------------------------------------------------
module ffba_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ffba_pkg::t_chain_ctl i_ctl,
    input  logic                i_lower,
    input  ffba_pkg::t_entry    i_right,
    input  logic                i_left_valid,
    output ffba_pkg::t_entry    o_entry
);

    ffba_pkg::t_entry r_entry;
    ffba_pkg::t_entry n_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.shift) begin
            n_entry = i_right;
        end else if (i_ctl.compact) begin
            if (i_lower) begin
                if (!r_entry.valid && i_right.valid) begin
                    n_entry = i_right;
                end
            end else begin
                if (!i_left_valid && r_entry.valid) begin
                    n_entry.valid = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry <= n_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

// ===== src/ffba_head.sv =====
// ----------------------------------------------------------------------------
// ffba_head
// Head of the block ring: sequences the scan and compaction passes, does
// first-fit, split, extension, free marking and merging on the entry that
// leaves cell 0, and holds the heap break and the result register.
// ----------------------------------------------------------------------------
module ffba_head #(
    parameter int HEAP_BYTES   = 65536,
    parameter int MAX_BLOCKS   = 32,
    parameter int HEADER_BYTES = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  ffba_pkg::t_in_item    i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output ffba_pkg::t_out_item   o_out_item,
    input  ffba_pkg::t_entry      i_head,
    input  logic                  i_tail_valid,
    input  logic                  i_packed,
    output ffba_pkg::t_chain_ctl  o_ctl,
    output ffba_pkg::t_entry      o_y
);

    localparam int          CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(MAX_BLOCKS);
    localparam logic [15:0] HDR16 = 16'(HEADER_BYTES);
    localparam logic [17:0] HDR18 = 18'(HEADER_BYTES);
    localparam logic [17:0] HEAP18 = 18'(HEAP_BYTES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_PACK,
        S_DONE
    } t_state;

    t_state                          r_state, n_state;
    logic                            r_op, n_op;
    logic [15:0]                     r_req, n_req;
    logic [15:0]                     r_faddr, n_faddr;
    ffba_pkg::t_entry                r_p, n_p;
    ffba_pkg::t_entry                r_q, n_q;
    logic                            r_done, n_done;
    logic                            r_found, n_found;
    logic                            r_full, n_full;
    logic                            r_phase, n_phase;
    logic [CNT_W-1:0]                r_cnt, n_cnt;
    logic [ffba_pkg::BREAK_W-1:0]    r_brk, n_brk;
    logic [15:0]                     r_addr, n_addr;
    ffba_pkg::t_status               r_status, n_status;
    logic                            r_out_valid, n_out_valid;
    ffba_pkg::t_out_item             r_out_item, n_out_item;

    logic [17:0]          pay;
    logic [17:0]          end_addr;
    logic                 oom;
    logic                 fits;
    logic                 split;
    ffba_pkg::t_entry     xm;
    ffba_pkg::t_entry     y;
    ffba_pkg::t_chain_ctl ctl;

    assign pay      = {1'b0, r_brk} + HDR18;
    assign end_addr = pay + {2'b00, r_req};
    assign oom      = (end_addr > HEAP18) || (pay >= HEAP18);
    assign fits     = i_head.valid && i_head.free && (i_head.size >= r_req);
    assign split    = ({2'b00, i_head.size} >= ({2'b00, r_req} + HDR18 + ffba_pkg::SPLIT_SLACK))
                      && !r_full;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_req       = r_req;
        n_faddr     = r_faddr;
        n_p         = r_p;
        n_q         = r_q;
        n_done      = r_done;
        n_found     = r_found;
        n_full      = r_full;
        n_phase     = r_phase;
        n_cnt       = r_cnt;
        n_brk       = r_brk;
        n_addr      = r_addr;
        n_status    = r_status;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_item  = r_out_item;
        y           = '0;
        ctl         = '0;
        xm          = i_head;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op     = i_in_item.opcode;
                    n_req    = i_in_item.request_size;
                    n_faddr  = i_in_item.free_address;
                    n_p      = '0;
                    n_q      = '0;
                    n_done   = 1'b0;
                    n_found  = 1'b0;
                    n_full   = i_tail_valid;
                    n_cnt    = '0;
                    n_addr   = '0;
                    n_status = ffba_pkg::STAT_OK;
                    if (i_in_item.opcode == ffba_pkg::OP_FREE
                            && i_in_item.free_address == 16'd0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                ctl.shift = 1'b1;
                n_cnt     = r_cnt + 1'b1;
                y         = r_p;
                if (r_op == ffba_pkg::OP_ALLOC) begin
                    if (r_q.valid) begin
                        // one entry of delay after a split, dropped at the next hole
                        n_p = r_q;
                        n_q = i_head.valid ? i_head : '0;
                    end else if (!r_done && fits) begin
                        n_done   = 1'b1;
                        n_addr   = i_head.start + HDR16;
                        n_status = ffba_pkg::STAT_OK;
                        if (split) begin
                            n_p.start = i_head.start;
                            n_p.size  = r_req;
                            n_p.free  = 1'b0;
                            n_p.valid = 1'b1;
                            n_q.start = i_head.start + HDR16 + r_req;
                            n_q.size  = i_head.size - r_req - HDR16;
                            n_q.free  = 1'b1;
                            n_q.valid = 1'b1;
                        end else begin
                            n_p      = i_head;
                            n_p.free = 1'b0;
                        end
                    end else if (!r_done && !i_head.valid && r_cnt != LAST && !oom) begin
                        // first empty slot after the last block: extend the heap
                        n_done    = 1'b1;
                        n_p.start = r_brk[15:0];
                        n_p.size  = r_req;
                        n_p.free  = 1'b0;
                        n_p.valid = 1'b1;
                        n_brk     = end_addr[ffba_pkg::BREAK_W-1:0];
                        n_addr    = pay[15:0];
                        n_status  = ffba_pkg::STAT_OK;
                    end else begin
                        n_p = i_head;
                    end
                end else begin
                    if (i_head.valid && !r_found
                            && ({1'b0, i_head.start} + {1'b0, HDR16}) == {1'b0, r_faddr}) begin
                        xm.free = 1'b1;
                        n_found = 1'b1;
                    end
                    if (r_p.valid && r_p.free && xm.valid && xm.free) begin
                        y          = '0;
                        n_p.size   = r_p.size + HDR16 + xm.size;
                    end else begin
                        n_p = xm;
                    end
                end
                if (r_cnt == LAST) begin
                    if (r_op == ffba_pkg::OP_ALLOC) begin
                        if (!n_done) begin
                            n_addr   = '0;
                            n_status = oom ? ffba_pkg::STAT_OOM : ffba_pkg::STAT_FULL;
                        end
                        n_state = S_DONE;
                    end else begin
                        n_addr   = '0;
                        n_status = n_found ? ffba_pkg::STAT_OK : ffba_pkg::STAT_BADADDR;
                        n_phase  = 1'b0;
                        n_state  = S_PACK;
                    end
                end
            end
            S_PACK: begin
                if (i_packed) begin
                    n_state = S_DONE;
                end else begin
                    ctl.compact = 1'b1;
                    ctl.phase   = r_phase;
                    n_phase     = ~r_phase;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid                = 1'b1;
                    n_out_item.payload_address = r_addr;
                    n_out_item.status          = r_status;
                    n_state                    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_brk       <= '0;
            r_out_valid <= 1'b0;
            r_phase     <= 1'b0;
            r_cnt       <= '0;
            r_done      <= 1'b0;
            r_found     <= 1'b0;
            r_p.valid   <= 1'b0;
            r_q.valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_brk       <= n_brk;
            r_out_valid <= n_out_valid;
            r_phase     <= n_phase;
            r_cnt       <= n_cnt;
            r_done      <= n_done;
            r_found     <= n_found;
            r_p         <= n_p;
            r_q         <= n_q;
        end
        r_op       <= n_op;
        r_req      <= n_req;
        r_faddr    <= n_faddr;
        r_full     <= n_full;
        r_addr     <= n_addr;
        r_status   <= n_status;
        r_out_item <= n_out_item;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign o_ctl       = ctl;
    assign o_y         = y;

endmodule
